### design/bfa_pkg.sv
// Shared types and constants of the bitmap fit allocator.
// Used by the run scanner and the top level; depends on nothing.
`timescale 1ns / 1ps

package bfa_pkg;

	// Default geometry of the free map.
	localparam int MapLinesDefault     = 4096;
	localparam int UnitsPerLineDefault = 16;

	// Configuration port.
	localparam int       ApbAddrW    = 3;
	localparam int       ApbDataW    = 32;
	localparam logic     RegStrategy = 1'b0;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_COMPACT = 2'd1,
		OP_WRITE   = 2'd2
	} op_t;

	// Placement policies held in the strategy register.
	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_NEXT  = 2'd1,
		FIT_BEST  = 2'd2,
		FIT_WORST = 2'd3
	} fit_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_MARK,
		ST_MARK_WAIT,
		ST_COUNT,
		ST_COUNT_WAIT,
		ST_FILL,
		ST_DONE
	} state_t;

	// Control from the sequencer to the run scanner.
	typedef struct packed {
		logic start;
		logic fit;
		logic worst;
	} scan_ctl_t;

	// Status from the run scanner back to the sequencer.
	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

endpackage

### design/bitmap_fit_allocator_top.sv
// Bitmap fit allocator. After reset the block clears every line of its map and
// accepts no request meanwhile. An allocate scans the whole map at one line per cycle
// through the single read port of the map memory; when the wrap-around scan of next
// fit runs, the two passes read MAP_LINES + 1 lines. A mark pass then rewrites each
// line that the placed units cover. A compact runs a count pass and a refill pass over
// the map; a map write and a zero-unit or oversized allocate go straight to the result.
// Depends on bfa_pkg, bfa_map_mem and bfa_run_scan.
`timescale 1ns / 1ps

module bitmap_fit_allocator_top import bfa_pkg::*; #(
	parameter int MAP_LINES      = MapLinesDefault,
	parameter int UNITS_PER_LINE = UnitsPerLineDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          operation,
	input  logic [16:0]         unit_count,
	input  logic [11:0]         line_index,
	input  logic [15:0]         line_bits,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                failed,
	output logic [15:0]         start_unit,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	localparam int TOTAL = MAP_LINES * UNITS_PER_LINE;
	localparam int AW    = MAP_LINES > 1 ? $clog2(MAP_LINES) : 1;
	localparam int UW    = TOTAL > 1 ? $clog2(TOTAL) : 1;
	localparam int LENW  = $clog2(TOTAL + 1);
	localparam int OFFW  = UNITS_PER_LINE > 1 ? $clog2(UNITS_PER_LINE) : 1;
	localparam int LNW   = $clog2(UNITS_PER_LINE + 1);
	localparam logic [AW-1:0] LastLine = AW'(MAP_LINES - 1);
	localparam logic [UNITS_PER_LINE-1:0] LineFree = '1;

	state_t state_q, state_d;

	logic [1:0]      strategy_q;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   end_q;
	logic [LENW-1:0] need_q;
	logic            pass2_q;
	logic            first_q;
	logic [OFFW-1:0] mask_off_q;
	logic [AW-1:0]   ptr_line_q;
	logic [OFFW-1:0] ptr_off_q;
	logic [LENW-1:0] rem_q;
	logic [OFFW-1:0] mark_off_q;
	logic [LENW-1:0] used_q;
	logic [LENW-1:0] base_q;
	logic            res_failed_q;
	logic [UW-1:0]   res_unit_q;
	logic            out_valid_q;
	logic            failed_q;
	logic [15:0]     start_unit_q;

	// Read pipeline stage that travels with the memory's read data.
	logic            scan_v_s1;
	logic            cnt_v_s1;
	logic            mark_v_s1;
	logic [AW-1:0]   addr_s1;
	logic            last_s1;
	logic [OFFW-1:0] mask_s1;
	logic [LNW-1:0]  lo_s1;
	logic [LNW-1:0]  hi_s1;

	// Memory ports.
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [UNITS_PER_LINE-1:0] mem_wdata;
	logic                      mem_re;
	logic [UNITS_PER_LINE-1:0] mem_rdata;

	// Scanner connection.
	scan_ctl_t                 scan_ctl;
	scan_stat_t                scan_stat;
	logic [UNITS_PER_LINE-1:0] scan_data;
	logic [UW-1:0]             found_unit;
	logic [AW-1:0]             found_line;
	logic [OFFW-1:0]           found_off;

	// Request decode and per-state helpers.
	logic            accept;
	logic            count_zero;
	logic            count_big;
	logic            alloc_go;
	logic            line_ok;
	logic            pass2_go;
	logic            out_free;
	logic [LNW-1:0]  mark_lo;
	logic [LNW-1:0]  mark_hi;
	logic [LNW-1:0]  mark_c;
	logic [LENW-1:0] rem_next;
	logic [UNITS_PER_LINE-1:0] mark_mask;
	logic [LNW-1:0]  fill_k;
	logic [UNITS_PER_LINE-1:0] fill_data;
	logic [LNW-1:0]  pop;

	bfa_map_mem #(
		.LINES (MAP_LINES),
		.WIDTH (UNITS_PER_LINE)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	bfa_run_scan #(
		.MAP_LINES      (MAP_LINES),
		.UNITS_PER_LINE (UNITS_PER_LINE)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.need       (need_q),
		.line_valid (scan_v_s1),
		.line_data  (scan_data),
		.line_addr  (addr_s1),
		.line_last  (last_s1),
		.stat       (scan_stat),
		.start_unit (found_unit),
		.start_line (found_line),
		.start_off  (found_off)
	);

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[ApbAddrW-1] == RegStrategy) ? ApbDataW'(strategy_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= FIT_FIRST;
		end else if (psel && penable && pwrite && paddr[ApbAddrW-1] == RegStrategy) begin
			strategy_q <= pwdata[1:0];
		end
	end

	// Request decode.
	always_comb begin
		accept     = in_valid && in_ready;
		count_zero = unit_count == '0;
		count_big  = 32'(unit_count) > 32'(TOTAL);
		alloc_go   = operation == OP_ALLOC && !count_zero && !count_big;
		line_ok    = 32'(line_index) < 32'(MAP_LINES);
		pass2_go   = scan_stat.done && !scan_stat.found && strategy_q == FIT_NEXT && !pass2_q;
		out_free   = !out_valid_q || out_ready;
	end

	// Span of units that the mark pass clears in the line it reads now.
	always_comb begin
		mark_lo  = first_q ? LNW'(mark_off_q) : '0;
		mark_c   = LNW'(UNITS_PER_LINE) - mark_lo;
		if (rem_q < LENW'(mark_c)) begin
			mark_c = LNW'(rem_q);
		end
		mark_hi  = mark_lo + mark_c;
		rem_next = rem_q - LENW'(mark_c);
	end

	// Line data fixed up for the scanner, the mark write and the used count.
	always_comb begin
		pop = '0;
		for (int j = 0; j < UNITS_PER_LINE; j++) begin
			scan_data[j] = mem_rdata[j] && LNW'(j) >= LNW'(mask_s1);
			mark_mask[j] = LNW'(j) >= lo_s1 && LNW'(j) < hi_s1;
			pop          = pop + LNW'(!mem_rdata[j]);
		end
	end

	// Refill line: used units packed from unit zero upward.
	always_comb begin
		if (used_q <= base_q) begin
			fill_k = '0;
		end else if (used_q - base_q >= LENW'(UNITS_PER_LINE)) begin
			fill_k = LNW'(UNITS_PER_LINE);
		end else begin
			fill_k = LNW'(used_q - base_q);
		end
		for (int j = 0; j < UNITS_PER_LINE; j++) begin
			fill_data[j] = LNW'(j) >= fill_k;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (addr_q == LastLine) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (alloc_go) begin
						state_d = ST_SCAN;
					end else if (operation == OP_COMPACT) begin
						state_d = ST_COUNT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (addr_q == end_q) state_d = ST_SCAN_WAIT;
			end
			ST_SCAN_WAIT: begin
				if (scan_stat.done) begin
					if (scan_stat.found) begin
						state_d = ST_MARK;
					end else if (pass2_go) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MARK: begin
				if (rem_next == '0) state_d = ST_MARK_WAIT;
			end
			ST_MARK_WAIT: state_d = ST_DONE;
			ST_COUNT: begin
				if (addr_q == LastLine) state_d = ST_COUNT_WAIT;
			end
			ST_COUNT_WAIT: state_d = ST_FILL;
			ST_FILL: begin
				if (addr_q == LastLine) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer: handshake, memory ports and scanner control.
	always_comb begin
		in_ready       = state_q == ST_IDLE;
		mem_re         = state_q == ST_SCAN || state_q == ST_COUNT || state_q == ST_MARK;
		mem_we         = 1'b0;
		mem_waddr      = addr_q;
		mem_wdata      = LineFree;
		scan_ctl.fit   = strategy_q == FIT_BEST || strategy_q == FIT_WORST;
		scan_ctl.worst = strategy_q == FIT_WORST;
		scan_ctl.start = 1'b0;
		if (mark_v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1;
			mem_wdata = mem_rdata & ~mark_mask;
		end
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				scan_ctl.start = accept && alloc_go;
				if (accept && operation == OP_WRITE && line_ok) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(line_index);
					mem_wdata = UNITS_PER_LINE'(line_bits);
				end
			end
			ST_SCAN_WAIT: begin
				scan_ctl.start = pass2_go;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = fill_data;
			end
			default: begin
			end
		endcase
	end

	// Read pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
			cnt_v_s1  <= 1'b0;
			mark_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= state_q == ST_SCAN;
			cnt_v_s1  <= state_q == ST_COUNT;
			mark_v_s1 <= state_q == ST_MARK;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		last_s1 <= addr_q == end_q;
		mask_s1 <= first_q ? mask_off_q : '0;
		lo_s1   <= mark_lo;
		hi_s1   <= mark_hi;
	end

	// Sequencer state and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			end_q        <= LastLine;
			need_q       <= '0;
			pass2_q      <= 1'b0;
			first_q      <= 1'b0;
			mask_off_q   <= '0;
			ptr_line_q   <= '0;
			ptr_off_q    <= '0;
			rem_q        <= '0;
			mark_off_q   <= '0;
			used_q       <= '0;
			base_q       <= '0;
			res_failed_q <= 1'b0;
			res_unit_q   <= '0;
			out_valid_q  <= 1'b0;
			failed_q     <= 1'b0;
			start_unit_q <= '0;
		end else begin
			state_q <= state_d;
			// Result register: loaded when the sequencer finishes, cleared when taken.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_v_s1) begin
				used_q <= used_q + LENW'(pop);
			end
			case (state_q)
				ST_CLEAR: begin
					addr_q <= (addr_q == LastLine) ? '0 : addr_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						res_failed_q <= operation == OP_ALLOC && count_big;
						res_unit_q   <= '0;
						if (alloc_go) begin
							need_q  <= LENW'(unit_count);
							pass2_q <= 1'b0;
							first_q <= 1'b1;
							end_q   <= LastLine;
							if (strategy_q == FIT_NEXT) begin
								addr_q     <= ptr_line_q;
								mask_off_q <= ptr_off_q;
							end else begin
								addr_q     <= '0;
								mask_off_q <= '0;
							end
						end else if (operation == OP_COMPACT) begin
							addr_q <= '0;
							used_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					addr_q  <= addr_q + AW'(1);
					first_q <= 1'b0;
				end
				ST_SCAN_WAIT: begin
					if (scan_stat.done) begin
						if (scan_stat.found) begin
							res_unit_q <= found_unit;
							addr_q     <= found_line;
							mark_off_q <= found_off;
							rem_q      <= need_q;
							first_q    <= 1'b1;
						end else if (pass2_go) begin
							addr_q     <= '0;
							end_q      <= ptr_line_q;
							mask_off_q <= '0;
							first_q    <= 1'b1;
							pass2_q    <= 1'b1;
						end else begin
							res_failed_q <= 1'b1;
						end
					end
				end
				ST_MARK: begin
					addr_q  <= addr_q + AW'(1);
					first_q <= 1'b0;
					rem_q   <= rem_next;
					// Next fit resumes right after the units just placed.
					if (rem_next == '0 && strategy_q == FIT_NEXT) begin
						if (mark_hi != LNW'(UNITS_PER_LINE)) begin
							ptr_line_q <= addr_q;
							ptr_off_q  <= OFFW'(mark_hi);
						end else if (addr_q == LastLine) begin
							ptr_line_q <= '0;
							ptr_off_q  <= '0;
						end else begin
							ptr_line_q <= addr_q + AW'(1);
							ptr_off_q  <= '0;
						end
					end
				end
				ST_COUNT: begin
					if (addr_q == LastLine) begin
						addr_q <= '0;
						base_q <= '0;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_FILL: begin
					addr_q <= addr_q + AW'(1);
					base_q <= base_q + LENW'(UNITS_PER_LINE);
				end
				ST_DONE: begin
					if (out_free) begin
						failed_q     <= res_failed_q;
						start_unit_q <= res_failed_q ? 16'd0 : 16'(res_unit_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign failed     = failed_q;
	assign start_unit = start_unit_q;

endmodule

### design/bfa_map_mem.sv
// Free map storage: one line of free marks per entry, one write and one read port.
// Read data is registered; depends on nothing.
`timescale 1ns / 1ps

module bfa_map_mem #(
	parameter int LINES = 4096,
	parameter int WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(LINES > 1 ? $clog2(LINES) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(LINES > 1 ? $clog2(LINES) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [LINES];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/bfa_run_scan.sv
// Run scanner: follows free runs across a stream of map lines, one line per cycle.
// Finds the earliest run that reaches the request (first fit) or the best or
// worst complete run (best/worst fit). Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_run_scan import bfa_pkg::*; #(
	parameter int MAP_LINES      = MapLinesDefault,
	parameter int UNITS_PER_LINE = UnitsPerLineDefault,
	localparam int TOTAL = MAP_LINES * UNITS_PER_LINE,
	localparam int AW    = MAP_LINES > 1 ? $clog2(MAP_LINES) : 1,
	localparam int UW    = TOTAL > 1 ? $clog2(TOTAL) : 1,
	localparam int LENW  = $clog2(TOTAL + 1),
	localparam int OFFW  = UNITS_PER_LINE > 1 ? $clog2(UNITS_PER_LINE) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  scan_ctl_t                 ctl,
	input  logic [LENW-1:0]           need,
	input  logic                      line_valid,
	input  logic [UNITS_PER_LINE-1:0] line_data,
	input  logic [AW-1:0]             line_addr,
	input  logic                      line_last,
	output scan_stat_t                stat,
	output logic [UW-1:0]             start_unit,
	output logic [AW-1:0]             start_line,
	output logic [OFFW-1:0]           start_off
);

	localparam int LNW = $clog2(UNITS_PER_LINE + 1);
	localparam int P2  = 1 << $clog2(UNITS_PER_LINE);

	// Stage 2: per-bit run length inside the line.
	logic                      v_s2;
	logic [UNITS_PER_LINE-1:0] free_s2;
	logic [LNW-1:0]            len_s2 [UNITS_PER_LINE];
	logic [AW-1:0]             line_s2;
	logic [LENW-1:0]           base_s2;
	logic                      last_s2;
	logic [LNW-1:0]            len_d [UNITS_PER_LINE];

	// Run carried in from the previous line, and the current pick.
	logic [LENW-1:0] carry_len_q;
	logic [UW-1:0]   carry_unit_q;
	logic [AW-1:0]   carry_line_q;
	logic [OFFW-1:0] carry_off_q;
	logic            found_q;
	logic            done_q;
	logic [LENW-1:0] pick_len_q;
	logic [UW-1:0]   pick_unit_q;
	logic [AW-1:0]   pick_line_q;
	logic [OFFW-1:0] pick_off_q;

	// Stage 3 combinational signals.
	logic [LENW-1:0]       run_end [UNITS_PER_LINE];
	logic [UNITS_PER_LINE-1:0] from_c;
	logic                  nv   [2*P2];
	logic [LENW-1:0]       nlen [2*P2];
	logic [OFFW-1:0]       nj   [2*P2];
	logic                  take_r;
	logic [OFFW-1:0]       sel_j;
	logic [OFFW-1:0]       sel_off;
	logic [UW-1:0]         sel_unit;
	logic [AW-1:0]         sel_line;
	logic                  sel_better;
	logic [OFFW-1:0]       top_off;
	logic                  take_pick;
	logic                  cend_v;
	logic                  use_c;
	logic                  any_v;
	logic [LENW-1:0]       any_len;
	logic                  any_from_c;

	// Length of the free run that ends at each bit, counted inside the line.
	always_comb begin
		for (int j = 0; j < UNITS_PER_LINE; j++) begin
			len_d[j] = LNW'(j + 1);
			for (int k = 0; k <= j; k++) begin
				if (!line_data[k]) begin
					len_d[j] = LNW'(j - k);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		free_s2 <= line_data;
		len_s2  <= len_d;
		line_s2 <= line_addr;
		base_s2 <= LENW'(32'(line_addr) * UNITS_PER_LINE);
		last_s2 <= line_last;
	end

	// Run ends with the carry added, and the candidate bits of this line.
	always_comb begin
		for (int i = 0; i < 2*P2; i++) begin
			nv[i]   = 1'b0;
			nlen[i] = '0;
			nj[i]   = '0;
		end
		for (int j = 0; j < UNITS_PER_LINE; j++) begin
			if (!free_s2[j]) begin
				run_end[j] = '0;
				from_c[j]  = 1'b0;
			end else if (len_s2[j] == LNW'(j + 1)) begin
				run_end[j] = carry_len_q + LENW'(j + 1);
				from_c[j]  = carry_len_q != '0;
			end else begin
				run_end[j] = LENW'(len_s2[j]);
				from_c[j]  = 1'b0;
			end
			nlen[P2+j] = run_end[j];
			nj[P2+j]   = OFFW'(j);
			if (j == UNITS_PER_LINE - 1) begin
				nv[P2+j] = free_s2[j] && run_end[j] >= need && (!ctl.fit || last_s2);
			end else begin
				nv[P2+j] = free_s2[j] && run_end[j] >= need && (!ctl.fit || !free_s2[j+1]);
			end
		end
		// Selection tree: lowest bit wins unless a fit mode prefers the other run.
		for (int i = P2 - 1; i >= 1; i--) begin
			take_r = nv[2*i+1] && (!nv[2*i] || (ctl.fit && (ctl.worst ?
				nlen[2*i+1] > nlen[2*i] : nlen[2*i+1] < nlen[2*i])));
			nv[i]   = take_r ? nv[2*i+1]   : nv[2*i];
			nlen[i] = take_r ? nlen[2*i+1] : nlen[2*i];
			nj[i]   = take_r ? nj[2*i+1]   : nj[2*i];
		end
	end

	// Start of the selected run and of the run that leaves the line.
	always_comb begin
		sel_j   = nj[1];
		sel_off = OFFW'(LNW'(sel_j) + LNW'(1) - len_s2[sel_j]);
		top_off = OFFW'(LNW'(UNITS_PER_LINE) - len_s2[UNITS_PER_LINE-1]);
		// A run carried in from earlier lines ends here when bit zero is used.
		// It lies lowest in the map, so it wins ties against runs of this line.
		cend_v     = ctl.fit && !free_s2[0] && carry_len_q != '0 && carry_len_q >= need;
		use_c      = cend_v && (!nv[1] || !(ctl.worst ? nlen[1] > carry_len_q :
			nlen[1] < carry_len_q));
		any_v      = cend_v || nv[1];
		any_len    = use_c ? carry_len_q : nlen[1];
		any_from_c = use_c || from_c[sel_j];
		if (any_from_c) begin
			sel_unit = carry_unit_q;
			sel_line = carry_line_q;
		end else begin
			sel_unit = UW'(base_s2 + LENW'(sel_off));
			sel_line = line_s2;
		end
		sel_better = ctl.worst ? any_len > pick_len_q : any_len < pick_len_q;
		take_pick  = any_v && (!found_q || (ctl.fit && sel_better));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_len_q <= '0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
		end else if (ctl.start) begin
			carry_len_q <= '0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= v_s2 && last_s2;
			if (v_s2) begin
				carry_len_q <= run_end[UNITS_PER_LINE-1];
				if (take_pick) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Payload of the carried run and of the pick.
	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (!from_c[UNITS_PER_LINE-1]) begin
				carry_unit_q <= UW'(base_s2 + LENW'(top_off));
				carry_line_q <= line_s2;
				carry_off_q  <= top_off;
			end
			if (take_pick) begin
				pick_len_q  <= any_len;
				pick_unit_q <= sel_unit;
				pick_line_q <= sel_line;
				pick_off_q  <= any_from_c ? carry_off_q : sel_off;
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.found = found_q;
	assign start_unit = pick_unit_q;
	assign start_line = pick_line_q;
	assign start_off  = pick_off_q;

endmodule
